// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used in the vector pair distance core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the cycle after.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/vpd_pkg.sv -----
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared widths, mode codes and record types of the vector pair distance core.
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int ELEM_W        = 16;  // width of an element port
  localparam int ELEM_BITS_DEF = 16;  // default number of element bits in use
  localparam int MODE_W        = 2;
  localparam int SQ_W          = 42;
  localparam int ABS_W         = 26;
  localparam int DOT_W         = 42;
  localparam int NORM_W        = 41;
  localparam int DIST_W        = 42;
  localparam int COS_W         = 16;
  localparam int Q_DEPTH       = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_EUCLID    = 2'd0,
    MODE_SQEUCLID  = 2'd1,
    MODE_MANHATTAN = 2'd2,
    MODE_COSINE    = 2'd3
  } mode_t;

  // Sums of one finished vector pair, with the mode that applies to it.
  typedef struct packed {
    mode_t                     mode;
    logic [SQ_W-1:0]           sq;
    logic [ABS_W-1:0]          abs;
    logic signed [DOT_W-1:0]   dot;
    logic [NORM_W-1:0]         na;
    logic [NORM_W-1:0]         nb;
  } sums_t;

  typedef struct packed {
    logic  valid;
    sums_t rec;
  } push_t;

  typedef struct packed {
    logic  avail;
    sums_t rec;
  } head_t;

endpackage

// ----- sv/vpd_front.sv -----
// ----------------------------------------------------------------------------
// vpd_front
// Takes one element pair per item, forms the products in a register stage and
// keeps saturating running sums. The last item of a pair pushes the sums.
// ----------------------------------------------------------------------------
module vpd_front #(
  parameter int ELEM_BITS = vpd_pkg::ELEM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [vpd_pkg::ELEM_W-1:0] in_a_element,
  input  logic [vpd_pkg::ELEM_W-1:0] in_b_element,
  input  logic                       in_last_element,
  input  vpd_pkg::mode_t             mode,
  output vpd_pkg::push_t             push,
  input  logic                       q_full
);
  import vpd_pkg::*;

  localparam int PW = 2 * ELEM_BITS;

  logic signed [ELEM_BITS-1:0] a_e;
  logic signed [ELEM_BITS-1:0] b_e;
  logic signed [ELEM_BITS:0]   diff;
  logic [ELEM_BITS:0]          diff_mag;
  logic [ELEM_BITS-1:0]        ad;
  logic [PW-1:0]               sq_prod;
  logic signed [PW-1:0]        aa_prod;
  logic signed [PW-1:0]        bb_prod;
  logic signed [PW-1:0]        ab_prod;

  logic                        vld_r;
  logic                        last_r;
  logic [ELEM_BITS-1:0]        ad_r;
  logic [PW-1:0]               sq_r;
  logic [PW-2:0]               aa_r;
  logic [PW-2:0]               bb_r;
  logic signed [PW-1:0]        ab_r;

  logic [SQ_W-1:0]             sq_sum_r,  sq_sum_nxt;
  logic [ABS_W-1:0]            abs_sum_r, abs_sum_nxt;
  logic signed [DOT_W-1:0]     dot_sum_r, dot_sum_nxt;
  logic [NORM_W-1:0]           na_sum_r,  na_sum_nxt;
  logic [NORM_W-1:0]           nb_sum_r,  nb_sum_nxt;

  logic [SQ_W:0]               sq_t;
  logic [ABS_W:0]              abs_t;
  logic signed [DOT_W:0]       dot_t;
  logic [NORM_W:0]             na_t;
  logic [NORM_W:0]             nb_t;
  logic                        adv;

  // Only the low ELEM_BITS bits of each element field carry the value.
  assign a_e      = in_a_element[ELEM_BITS-1:0];
  assign b_e      = in_b_element[ELEM_BITS-1:0];
  assign diff     = (ELEM_BITS+1)'(a_e) - (ELEM_BITS+1)'(b_e);
  assign diff_mag = diff[ELEM_BITS] ? (ELEM_BITS+1)'(-diff) : diff;
  assign ad       = diff_mag[ELEM_BITS-1:0];
  assign sq_prod  = PW'(ad) * PW'(ad);
  assign aa_prod  = PW'(a_e) * PW'(a_e);
  assign bb_prod  = PW'(b_e) * PW'(b_e);
  assign ab_prod  = PW'(a_e) * PW'(b_e);

  // The product stage holds when a last item waits for room in the queue.
  assign adv      = !(vld_r && last_r && q_full);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      last_r <= in_last_element;
      ad_r   <= ad;
      sq_r   <= sq_prod;
      aa_r   <= aa_prod[PW-2:0];
      bb_r   <= bb_prod[PW-2:0];
      ab_r   <= ab_prod;
    end
  end

  always_comb begin
    sq_t  = {1'b0, sq_sum_r} + (SQ_W+1)'(sq_r);
    abs_t = {1'b0, abs_sum_r} + (ABS_W+1)'(ad_r);
    na_t  = {1'b0, na_sum_r} + (NORM_W+1)'(aa_r);
    nb_t  = {1'b0, nb_sum_r} + (NORM_W+1)'(bb_r);
    dot_t = (DOT_W+1)'(dot_sum_r) + (DOT_W+1)'(ab_r);

    sq_sum_nxt  = sq_t[SQ_W]     ? '1 : sq_t[SQ_W-1:0];
    abs_sum_nxt = abs_t[ABS_W]   ? '1 : abs_t[ABS_W-1:0];
    na_sum_nxt  = na_t[NORM_W]   ? '1 : na_t[NORM_W-1:0];
    nb_sum_nxt  = nb_t[NORM_W]   ? '1 : nb_t[NORM_W-1:0];
    if (dot_t[DOT_W] != dot_t[DOT_W-1]) begin
      dot_sum_nxt = dot_t[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_sum_nxt = dot_t[DOT_W-1:0];
    end

    push.valid    = vld_r && last_r && !q_full;
    push.rec.mode = mode;
    push.rec.sq   = sq_sum_nxt;
    push.rec.abs  = abs_sum_nxt;
    push.rec.dot  = dot_sum_nxt;
    push.rec.na   = na_sum_nxt;
    push.rec.nb   = nb_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_sum_r  <= '0;
      abs_sum_r <= '0;
      dot_sum_r <= '0;
      na_sum_r  <= '0;
      nb_sum_r  <= '0;
    end else if (adv && vld_r) begin
      if (last_r) begin
        sq_sum_r  <= '0;
        abs_sum_r <= '0;
        dot_sum_r <= '0;
        na_sum_r  <= '0;
        nb_sum_r  <= '0;
      end else begin
        sq_sum_r  <= sq_sum_nxt;
        abs_sum_r <= abs_sum_nxt;
        dot_sum_r <= dot_sum_nxt;
        na_sum_r  <= na_sum_nxt;
        nb_sum_r  <= nb_sum_nxt;
      end
    end
  end

endmodule

// ----- sv/vpd_queue.sv -----
// ----------------------------------------------------------------------------
// vpd_queue
// Two-entry queue of finished sums between the accumulator and the back end.
// ----------------------------------------------------------------------------
module vpd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  vpd_pkg::push_t push,
  input  logic           pop,
  output vpd_pkg::head_t head,
  output logic           full
);
  import vpd_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  sums_t             entries [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNT_W'(Q_DEPTH));
  assign head.avail = (count_r != '0);
  assign head.rec   = entries[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push.valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr_r] <= push.rec;
    end
  end

endmodule

// ----- sv/vpd_back.sv -----
// ----------------------------------------------------------------------------
// vpd_back
// Turns one set of sums into a result. Holds a shared 42x14 multiplier, a
// restoring divider and a bit-serial square root, run by a small sequencer.
// ----------------------------------------------------------------------------
module vpd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vpd_pkg::head_t                   head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [vpd_pkg::DIST_W-1:0]       out_distance,
  output logic signed [vpd_pkg::COS_W-1:0] out_cosine_q15,
  output logic                             out_zero_norm
);
  import vpd_pkg::*;

  localparam int MAG_W     = DOT_W;            // magnitude of the dot product
  localparam int CHUNK_W   = 14;               // multiplier digit
  localparam int MUL_STEPS = MAG_W / CHUNK_W;  // digits per product
  localparam int ACC_W     = 2 * MAG_W;
  localparam int DEN_W     = 2 * NORM_W;       // norm product
  localparam int NUM_W     = 2 * MAG_W - 1;    // dot magnitude squared
  localparam int QSHIFT    = 30;               // two Q15 fractions
  localparam int REM_W     = NUM_W + QSHIFT;
  localparam int QUO_W     = 31;               // quotients at or above 2^31 saturate
  localparam int SQ_OPW    = SQ_W;
  localparam int CNT_W     = 5;
  localparam logic [SQ_OPW-1:0] SQ_ONE_INIT = {2'b01, {(SQ_OPW-2){1'b0}}};
  localparam logic [COS_W:0]    COS_POS_MAX = 17'd32767;
  localparam logic [COS_W:0]    COS_NEG_MAG = 17'd32768;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_SQRT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  mode_t                    mode_r, mode_nxt;
  logic                     neg_r, neg_nxt;
  logic                     phase_r, phase_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic [MAG_W-1:0]         mul_a_r, mul_a_nxt;
  logic [MAG_W-1:0]         mul_b_r, mul_b_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [REM_W-1:0]         dsh_r, dsh_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic [SQ_OPW-1:0]        sq_op_r, sq_op_nxt;
  logic [SQ_OPW-1:0]        sq_res_r, sq_res_nxt;
  logic [SQ_OPW-1:0]        sq_one_r, sq_one_nxt;
  logic [DIST_W-1:0]        dist_r, dist_nxt;
  logic signed [COS_W-1:0]  cos_r, cos_nxt;
  logic                     zn_r, zn_nxt;

  logic [MAG_W+CHUNK_W-1:0] mul_prod;
  logic [ACC_W-1:0]         acc_step;
  logic                     div_ge;
  logic [REM_W-1:0]         rem_sub;
  logic [QUO_W-1:0]         quo_step;
  logic [SQ_OPW-1:0]        sq_trial;
  logic                     sq_ge;
  logic [SQ_OPW-1:0]        sq_res_step;
  logic [COS_W:0]           root_q;
  logic [COS_W:0]           q_lim;
  logic signed [COS_W-1:0]  cos_root;
  logic [MAG_W-1:0]         head_mag;

  // Most significant digit first, so the accumulator shifts left each step.
  assign mul_prod = (MAG_W+CHUNK_W)'(mul_a_r) * (MAG_W+CHUNK_W)'(mul_b_r[MAG_W-1 -: CHUNK_W]);
  assign acc_step = {acc_r[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(mul_prod);

  assign div_ge   = (rem_r >= dsh_r);
  assign rem_sub  = rem_r - dsh_r;
  assign quo_step = {quo_r[QUO_W-2:0], div_ge};

  assign sq_trial    = sq_res_r + sq_one_r;
  assign sq_ge       = (sq_op_r >= sq_trial);
  assign sq_res_step = sq_ge ? (sq_res_r >> 1) + sq_one_r : (sq_res_r >> 1);

  // The cosine root stays below 46341, so 17 bits hold it.
  assign root_q = sq_res_step[COS_W:0];

  always_comb begin
    if (neg_r) begin
      q_lim    = (root_q > COS_NEG_MAG) ? COS_NEG_MAG : root_q;
      cos_root = COS_W'(~q_lim + 1'b1);
    end else begin
      q_lim    = (root_q > COS_POS_MAX) ? COS_POS_MAX : root_q;
      cos_root = q_lim[COS_W-1:0];
    end
  end

  assign head_mag = head.rec.dot[DOT_W-1] ? MAG_W'(-head.rec.dot) : MAG_W'(head.rec.dot);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    neg_nxt    = neg_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    mag_nxt    = mag_r;
    mul_a_nxt  = mul_a_r;
    mul_b_nxt  = mul_b_r;
    acc_nxt    = acc_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    quo_nxt    = quo_r;
    sq_op_nxt  = sq_op_r;
    sq_res_nxt = sq_res_r;
    sq_one_nxt = sq_one_r;
    dist_nxt   = dist_r;
    cos_nxt    = cos_r;
    zn_nxt     = zn_r;
    pop        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (head.avail) begin
          pop        = 1'b1;
          mode_nxt   = head.rec.mode;
          dist_nxt   = '0;
          cos_nxt    = '0;
          zn_nxt     = 1'b0;
          sq_res_nxt = '0;
          sq_one_nxt = SQ_ONE_INIT;
          case (head.rec.mode)
            MODE_EUCLID: begin
              sq_op_nxt = head.rec.sq;
              state_nxt = S_SQRT;
            end
            MODE_SQEUCLID: begin
              dist_nxt  = head.rec.sq;
              state_nxt = S_OUT;
            end
            MODE_MANHATTAN: begin
              dist_nxt  = DIST_W'(head.rec.abs);
              state_nxt = S_OUT;
            end
            default: begin
              if ((head.rec.na == '0) || (head.rec.nb == '0)) begin
                zn_nxt    = 1'b1;
                state_nxt = S_OUT;
              end else begin
                neg_nxt   = head.rec.dot[DOT_W-1];
                mag_nxt   = head_mag;
                mul_a_nxt = MAG_W'(head.rec.na);
                mul_b_nxt = MAG_W'(head.rec.nb);
                acc_nxt   = '0;
                cnt_nxt   = CNT_W'(MUL_STEPS - 1);
                phase_nxt = 1'b0;
                state_nxt = S_MUL;
              end
            end
          endcase
        end
      end

      // First the norm product, then the squared dot magnitude.
      S_MUL: begin
        acc_nxt   = acc_step;
        mul_b_nxt = mul_b_r << CHUNK_W;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (!phase_r) begin
            den_nxt   = acc_step[DEN_W-1:0];
            mul_a_nxt = mag_r;
            mul_b_nxt = mag_r;
            acc_nxt   = '0;
            cnt_nxt   = CNT_W'(MUL_STEPS - 1);
            phase_nxt = 1'b1;
          end else begin
            rem_nxt   = {acc_step[NUM_W-1:0], {QSHIFT{1'b0}}};
            dsh_nxt   = REM_W'({den_r, {QUO_W{1'b0}}});
            state_nxt = S_CHK;
          end
        end
      end

      // A quotient of 2^31 or more saturates the cosine.
      S_CHK: begin
        if (div_ge) begin
          cos_nxt   = neg_r ? COS_W'(~COS_NEG_MAG + 1'b1) : COS_POS_MAX[COS_W-1:0];
          state_nxt = S_OUT;
        end else begin
          dsh_nxt   = dsh_r >> 1;
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(QUO_W - 1);
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_ge) begin
          rem_nxt = rem_sub;
        end
        quo_nxt = quo_step;
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          sq_op_nxt = SQ_OPW'(quo_step);
          state_nxt = S_SQRT;
        end
      end

      S_SQRT: begin
        if (sq_ge) begin
          sq_op_nxt = sq_op_r - sq_trial;
        end
        sq_res_nxt = sq_res_step;
        sq_one_nxt = sq_one_r >> 2;
        if (sq_one_r[0]) begin
          if (mode_r == MODE_EUCLID) begin
            dist_nxt = DIST_W'(sq_res_step);
          end else begin
            cos_nxt = cos_root;
          end
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    neg_r    <= neg_nxt;
    phase_r  <= phase_nxt;
    cnt_r    <= cnt_nxt;
    mag_r    <= mag_nxt;
    mul_a_r  <= mul_a_nxt;
    mul_b_r  <= mul_b_nxt;
    acc_r    <= acc_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    quo_r    <= quo_nxt;
    sq_op_r  <= sq_op_nxt;
    sq_res_r <= sq_res_nxt;
    sq_one_r <= sq_one_nxt;
    dist_r   <= dist_nxt;
    cos_r    <= cos_nxt;
    zn_r     <= zn_nxt;
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_distance   = dist_r;
  assign out_cosine_q15 = cos_r;
  assign out_zero_norm  = zn_r;

endmodule

// ----- sv/vector_pair_distance_core.sv -----
// ----------------------------------------------------------------------------
// vector_pair_distance_core
// Streaming Euclidean, squared Euclidean, Manhattan or cosine distance between
// two vectors fed one coordinate pair per item.
// ----------------------------------------------------------------------------
//   Channel  Handshake          Payload
//   in       in_valid/in_stall  in_a_element, in_b_element, in_last_element
//   out      out_valid/out_stall out_distance, out_cosine_q15, out_zero_norm
//   cfg      cfg_valid/cfg_ready cfg_distance_mode
//
// The accumulator takes one item per cycle; its sums reach the back end through a
// two-entry queue, so it stalls only when both entries wait.
// Back end per result: squared Euclidean and Manhattan pass straight to the output;
// Euclidean runs the 21-step root; cosine runs two 3-digit products, the range
// check, the 31-step divider and the root, or stops after the check when it
// saturates early; a zero norm passes straight to the output.
// Reset is synchronous and clears the sums, the queue and the mode register.
// A stalled result holds the back end; the queue keeps taking sums meanwhile.
// ----------------------------------------------------------------------------
module vector_pair_distance_core #(
  parameter int ELEM_BITS = vpd_pkg::ELEM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [vpd_pkg::ELEM_W-1:0]    in_a_element,
  input  logic signed [vpd_pkg::ELEM_W-1:0]    in_b_element,
  input  logic                                 in_last_element,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [vpd_pkg::DIST_W-1:0]           out_distance,
  output logic signed [vpd_pkg::COS_W-1:0]     out_cosine_q15,
  output logic                                 out_zero_norm,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vpd_pkg::MODE_W-1:0]           cfg_distance_mode
);
  import vpd_pkg::*;

  `include "assert_macros.svh"

  mode_t mode_r;
  push_t q_push;
  head_t q_head;
  logic  q_full;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EUCLID;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= mode_t'(cfg_distance_mode);
    end
  end

  vpd_front #(
    .ELEM_BITS(ELEM_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_a_element   (in_a_element),
    .in_b_element   (in_b_element),
    .in_last_element(in_last_element),
    .mode           (mode_r),
    .push           (q_push),
    .q_full         (q_full)
  );

  vpd_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .pop  (q_pop),
    .head (q_head),
    .full (q_full)
  );

  vpd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_distance  (out_distance),
    .out_cosine_q15(out_cosine_q15),
    .out_zero_norm (out_zero_norm)
  );

  `ASSERT_IMPLIES(a_push_room, clk, rst_n, q_push.valid, !q_full, "sums pushed into a full queue")
  `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, q_full, "input stalled with room in the queue")
  `ASSERT_NEXT(a_push_seen, clk, rst_n, q_push.valid, q_head.avail, "pushed sums not visible at the queue head")
  `ASSERT_IMPLIES(a_zero_norm_only, clk, rst_n, out_valid && out_zero_norm, (out_cosine_q15 == '0) && (out_distance == '0), "zero norm result carries a value")

endmodule

// ----- tb/vpd_result_checker.sv -----
// ----------------------------------------------------------------------------
// vpd_result_checker
// Watches the item, result and mode register channels of the vector pair
// distance core, keeps its own running sums, and compares every result with the
// distance it predicts for the finished vector pair.
// ----------------------------------------------------------------------------
module vpd_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [vpd_pkg::ELEM_W-1:0]    in_a_element,
  input  logic [vpd_pkg::ELEM_W-1:0]    in_b_element,
  input  logic                          in_last_element,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [vpd_pkg::DIST_W-1:0]    out_distance,
  input  logic [vpd_pkg::COS_W-1:0]     out_cosine_q15,
  input  logic                          out_zero_norm,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [vpd_pkg::MODE_W-1:0]    cfg_distance_mode,
  output int                            errors,
  output int                            pending
);
  import vpd_pkg::*;

  localparam int     EB       = ELEM_BITS_DEF;
  localparam longint SQ_MAX   = (64'sd1 <<< SQ_W) - 1;
  localparam longint ABS_MAX  = (64'sd1 <<< ABS_W) - 1;
  localparam longint NORM_MAX = (64'sd1 <<< NORM_W) - 1;
  localparam longint DOT_MAX  = (64'sd1 <<< (DOT_W - 1)) - 1;
  localparam longint DOT_MIN  = -(64'sd1 <<< (DOT_W - 1));

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic [COS_W-1:0]  cosine;
    logic              zero_norm;
  } pair_result_t;

  longint       sq_diff_sum;
  longint       abs_diff_sum;
  longint       dot_sum;
  longint       norm_a_sum;
  longint       norm_b_sum;
  mode_t        mode_reg;
  pair_result_t expected_results[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint elem_value(input logic [ELEM_W-1:0] raw);
    longint v;
    v = longint'(raw) & ((64'sd1 <<< EB) - 1);
    if (raw[EB-1]) v = v - (64'sd1 <<< EB);
    return v;
  endfunction

  function automatic longint sat_add(input longint s, input longint v, input longint mx);
    return (s + v > mx) ? mx : s + v;
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint r;
    longint c;
    int     k;
    r = 0;
    for (k = 31; k >= 0; k--) begin
      c = r | (64'sd1 <<< k);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Largest q with q * sqrt(na * nb) <= |dot| * 2^15, compared in squares.
  function automatic logic [COS_W-1:0] cosine_q15(input longint dot, input longint na,
                                                  input longint nb);
    logic [127:0] rhs;
    logic [127:0] nn;
    logic [127:0] lhs;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic [63:0]  c;
    int           k;
    mag = (dot < 0) ? 64'(-dot) : 64'(dot);
    rhs = 128'(mag) * 128'(mag);
    rhs = rhs << 30;
    nn  = 128'(na) * 128'(nb);
    q   = '0;
    for (k = 15; k >= 0; k--) begin
      c   = q | (64'd1 << k);
      lhs = 128'(c * c) * nn;
      if (lhs <= rhs) q = c;
    end
    if (dot < 0) begin
      if (q > 64'd32768) q = 64'd32768;
      return COS_W'(64'd0 - q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return COS_W'(q);
  endfunction

  task automatic take_element(input logic [ELEM_W-1:0] a_raw, input logic [ELEM_W-1:0] b_raw,
                              input logic last);
    longint       a;
    longint       b;
    longint       d;
    longint       ad;
    pair_result_t r;
    a  = elem_value(a_raw);
    b  = elem_value(b_raw);
    d  = a - b;
    ad = (d < 0) ? -d : d;
    sq_diff_sum  = sat_add(sq_diff_sum, ad * ad, SQ_MAX);
    abs_diff_sum = sat_add(abs_diff_sum, ad, ABS_MAX);
    norm_a_sum   = sat_add(norm_a_sum, a * a, NORM_MAX);
    norm_b_sum   = sat_add(norm_b_sum, b * b, NORM_MAX);
    dot_sum      = dot_sum + a * b;
    if (dot_sum > DOT_MAX) dot_sum = DOT_MAX;
    else if (dot_sum < DOT_MIN) dot_sum = DOT_MIN;
    if (last) begin
      r.distance  = '0;
      r.cosine    = '0;
      r.zero_norm = 1'b0;
      case (mode_reg)
        MODE_EUCLID:    r.distance = DIST_W'(floor_sqrt(sq_diff_sum));
        MODE_SQEUCLID:  r.distance = DIST_W'(sq_diff_sum);
        MODE_MANHATTAN: r.distance = DIST_W'(abs_diff_sum);
        default: begin
          if (norm_a_sum == 0 || norm_b_sum == 0) r.zero_norm = 1'b1;
          else r.cosine = cosine_q15(dot_sum, norm_a_sum, norm_b_sum);
        end
      endcase
      expected_results.push_back(r);
      sq_diff_sum  = 0;
      abs_diff_sum = 0;
      dot_sum      = 0;
      norm_a_sum   = 0;
      norm_b_sum   = 0;
    end
  endtask

  task automatic check_result();
    pair_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no finished vector pair waiting for it");
      return;
    end
    want = expected_results.pop_front();
    if (out_distance !== want.distance)
      report_mismatch($sformatf("distance %0d, expected %0d", out_distance, want.distance));
    if (out_cosine_q15 !== want.cosine)
      report_mismatch($sformatf("cosine %0d, expected %0d", $signed(out_cosine_q15),
                                $signed(want.cosine)));
    if (out_zero_norm !== want.zero_norm)
      report_mismatch($sformatf("zero norm flag %b, expected %b", out_zero_norm,
                                want.zero_norm));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sq_diff_sum  = 0;
      abs_diff_sum = 0;
      dot_sum      = 0;
      norm_a_sum   = 0;
      norm_b_sum   = 0;
      mode_reg     = MODE_EUCLID;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) mode_reg = mode_t'(cfg_distance_mode);
      // A result never leaves in the cycle its last item enters, so compare first.
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_element(in_a_element, in_b_element, in_last_element);
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/vector_pair_distance_core_tb.sv -----
// ----------------------------------------------------------------------------
// vector_pair_distance_core_tb
// Streams vector pairs into the distance core in all four modes under changing
// sender gaps and receiver stalls; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module vector_pair_distance_core_tb;
  import vpd_pkg::*;

  localparam int     DRAIN_CYCLES  = 80;
  localparam int     RANDOM_PHASES = 16;
  localparam int     PHASE_ITEMS   = 40;
  localparam int     LONG_ITEMS    = 1030;
  localparam longint LIMIT_CYCLES  = 3_000_000;

  logic                     clk               = 1'b0;
  logic                     rst_n             = 1'b0;
  logic                     in_valid          = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] in_a_element      = '0;
  logic signed [ELEM_W-1:0] in_b_element      = '0;
  logic                     in_last_element   = 1'b0;
  logic                     out_valid;
  logic                     out_stall         = 1'b0;
  logic [DIST_W-1:0]        out_distance;
  logic signed [COS_W-1:0]  out_cosine_q15;
  logic                     out_zero_norm;
  logic                     cfg_valid         = 1'b0;
  logic                     cfg_ready;
  logic [MODE_W-1:0]        cfg_distance_mode = '0;

  int check_errors;
  int pending_results;
  int idle_pct  = 0;
  int stall_pct = 0;
  int item_count;
  int pair_count;

  always #6 clk = ~clk;

  vector_pair_distance_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_a_element      (in_a_element),
    .in_b_element      (in_b_element),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_distance      (out_distance),
    .out_cosine_q15    (out_cosine_q15),
    .out_zero_norm     (out_zero_norm),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_distance_mode (cfg_distance_mode)
  );

  vpd_result_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_a_element      (in_a_element),
    .in_b_element      (in_b_element),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_distance      (out_distance),
    .out_cosine_q15    (out_cosine_q15),
    .out_zero_norm     (out_zero_norm),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_distance_mode (cfg_distance_mode),
    .errors            (check_errors),
    .pending           (pending_results)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic set_profile(input int p);
    case (p)
      1:       begin idle_pct = 64; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 64; end
      3:       begin idle_pct = 38; stall_pct = 38; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic write_mode(input mode_t m);
    cfg_valid         <= 1'b1;
    cfg_distance_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_a_element    <= a;
    in_b_element    <= b;
    in_last_element <= last;
    do @(posedge clk); while (in_stall);
    item_count++;
    if (last) pair_count++;
  endtask

  // Waits out every result, then the back end's longest pass, so the mode can change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] random_elem();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return ELEM_W'($urandom_range(16) - 8);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic send_random_pair(input int len);
    int                kind;
    int                n;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    // Equal, opposite and all-zero vectors reach the cosine edge cases.
    kind = $urandom_range(9);
    for (n = 0; n < len; n++) begin
      a = random_elem();
      b = random_elem();
      case (kind)
        6:       b = a;
        7:       b = -a;
        8:       a = '0;
        9:       b = '0;
        default: ;
      endcase
      send_item(a, b, n == len - 1);
    end
  endtask

  // Extreme elements on a vector longer than the difference sums are sized for, so they
  // saturate.
  task automatic send_long_pair(input int len);
    int n;
    for (n = 0; n < len; n++) begin
      if ($urandom_range(1)) send_item(16'h8000, 16'h7fff, n == len - 1);
      else send_item(16'h7fff, 16'h8000, n == len - 1);
    end
  endtask

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int    p;
    int    sent;
    int    len;
    mode_t m;
    item_count = 0;
    pair_count = 0;
    set_profile(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_EUCLID);
    send_item(16'h7fff, 16'h8000, 1'b1);
    send_item(16'h0000, 16'h0000, 1'b1);
    send_item(16'h0003, 16'h0000, 1'b0);
    send_item(16'h0000, 16'h0004, 1'b1);
    drain();
    write_mode(MODE_SQEUCLID);
    send_item(16'h8000, 16'h7fff, 1'b1);
    send_item(16'h0001, 16'hffff, 1'b1);
    drain();
    write_mode(MODE_MANHATTAN);
    send_item(16'h8000, 16'h7fff, 1'b1);
    send_item(16'hffff, 16'h0001, 1'b0);
    send_item(16'h0005, 16'h0002, 1'b1);
    drain();
    write_mode(MODE_COSINE);
    send_item(16'h0005, 16'h0005, 1'b1);
    send_item(16'h8000, 16'h7fff, 1'b1);
    send_item(16'h7fff, 16'h8001, 1'b1);
    send_item(16'h0000, 16'h0007, 1'b1);
    send_item(16'h0000, 16'h0000, 1'b1);
    send_item(16'h0003, 16'h0000, 1'b0);
    send_item(16'h0000, 16'h0004, 1'b1);
    send_item(16'h0001, 16'h0002, 1'b0);
    send_item(16'h0002, 16'h0004, 1'b1);
    drain();

    // Every mode meets every idling profile once.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      set_profile(p % 4);
      m = mode_t'(MODE_W'((p + p / 4) % 4));
      write_mode(m);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        send_random_pair(len);
        sent += len;
      end
      drain();
    end

    set_profile(3);
    write_mode(MODE_SQEUCLID);
    send_long_pair(LONG_ITEMS);
    drain();

    $display("Covered %0d items in %0d vector pairs over all four distance modes,",
             item_count, pair_count);
    $display("with zero norms, cosine extremes and saturated sums on a long vector.");
    if (check_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- vector_pair_distance_core.f -----
+incdir+sv
sv/vpd_pkg.sv
sv/vpd_front.sv
sv/vpd_queue.sv
sv/vpd_back.sv
sv/vector_pair_distance_core.sv
tb/vpd_result_checker.sv
tb/vector_pair_distance_core_tb.sv
